FILE: src/tfr_pkg.sv
// Package with the item types, phase codes, event codes and limits of the tape frame recognizer.
package tfr_pkg;

  localparam logic [16:0] POS_MAX   = 17'h1FFFF;
  localparam logic [16:0] POS_START = 17'd2;
  localparam logic [16:0] POS_00    = 17'd18;
  localparam logic [16:0] POS_55    = 17'd34;
  localparam logic [16:0] POS_HEAD  = 17'd50;
  localparam logic [16:0] POS_LEN_L = 17'd54;
  localparam logic [16:0] POS_LEN_H = 17'd55;
  localparam logic [16:0] POS_HEND  = 17'd65;
  localparam logic [16:0] POS_BODY  = 17'd67;
  localparam logic [16:0] HEAD_LEN  = 17'd63;

  localparam logic [7:0] SYNC_FF = 8'hFF;
  localparam logic [7:0] SYNC_00 = 8'h00;
  localparam logic [7:0] SYNC_55 = 8'h55;

  localparam int unsigned EXT_BLOCK_WAIT_TICKS = 4096;
  localparam int unsigned EXT_BLOCK_GAP_TICKS  = 1024;
  localparam logic [15:0] WAIT_LOAD = 16'(EXT_BLOCK_WAIT_TICKS);
  localparam logic [15:0] GAP_LOAD  = 16'(EXT_BLOCK_GAP_TICKS);
  localparam logic [15:0] REWAIT_LOAD = 16'(EXT_BLOCK_WAIT_TICKS - EXT_BLOCK_GAP_TICKS);

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_STORED = 3'd1;
  localparam logic [2:0] EV_SYNC   = 3'd2;
  localparam logic [2:0] EV_HEADER = 3'd3;
  localparam logic [2:0] EV_RECORD = 3'd4;
  localparam logic [2:0] EV_EXT    = 3'd5;
  localparam logic [2:0] EV_BUSY   = 3'd6;

  typedef enum logic [2:0] {
    PH_FF   = 3'd0,
    PH_00   = 3'd1,
    PH_55   = 3'd2,
    PH_HEAD = 3'd3,
    PH_BODY = 3'd4,
    PH_WAIT = 3'd5,
    PH_EXT  = 3'd6
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       receiver_busy;
    logic       host_accepts;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [16:0] byte_index;
    logic [7:0]  stored_byte;
    logic [16:0] record_length;
  } out_item_t;

endpackage

FILE: src/tape_record_frame_recognizer_unit.sv
// Tape save record frame recognizer: framing state machine with a registered, skid-buffered result.
//
// Each input item is either a transmitted byte or one tape half-clock tick, and each one yields
// exactly one result item. The framing state is updated in the cycle an item is accepted, and
// the result is written on the same edge to the output register, or to the skid register while
// out_stall holds it. A new item can be accepted in every cycle; the rate is set only by the
// output side, since a two-entry output stage (output register plus skid register) holds results
// while out_stall is high and in_stall rises only when both entries are full.
module tape_record_frame_recognizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tfr_pkg::out_item_t out_item
);

  tfr_pkg::phase_t    phase_r, phase_nxt;
  logic [16:0]        position_r, position_nxt;
  logic [16:0]        body_end_r, body_end_nxt;
  logic [7:0]         length_low_r, length_low_nxt;
  logic [7:0]         length_high_r, length_high_nxt;
  logic [15:0]        gap_ticks_r, gap_ticks_nxt;

  logic               out_valid_r;
  tfr_pkg::out_item_t out_item_r;
  logic               skid_valid_r;
  tfr_pkg::out_item_t skid_item_r;

  tfr_pkg::out_item_t res;
  logic               accept;
  logic [16:0]        pos_bump;
  logic [15:0]        gap_dec;
  logic [15:0]        blen;
  logic               sync_err;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign pos_bump = (position_r < tfr_pkg::POS_MAX) ? position_r + 17'd1 : position_r;
  assign gap_dec  = gap_ticks_r - 16'd1;

  always_comb begin
    phase_nxt       = phase_r;
    position_nxt    = position_r;
    body_end_nxt    = body_end_r;
    length_low_nxt  = length_low_r;
    length_high_nxt = length_high_r;
    gap_ticks_nxt   = gap_ticks_r;
    res             = '0;
    blen            = '0;
    sync_err        = 1'b0;
    if (in_item.command == tfr_pkg::CMD_BYTE) begin
      if (in_item.receiver_busy) begin
        phase_nxt     = tfr_pkg::PH_FF;
        position_nxt  = tfr_pkg::POS_START;
        res.event_res = tfr_pkg::EV_BUSY;
      end else begin
        res.byte_index  = position_r;
        res.stored_byte = in_item.data_byte;
        res.event_res   = tfr_pkg::EV_STORED;
        unique case (phase_r)
          tfr_pkg::PH_FF: begin
            if (in_item.data_byte == tfr_pkg::SYNC_FF) begin
              position_nxt = pos_bump;
              if (pos_bump == tfr_pkg::POS_00) begin
                phase_nxt = tfr_pkg::PH_00;
              end
            end else begin
              sync_err = 1'b1;
            end
          end
          tfr_pkg::PH_00: begin
            if (in_item.data_byte == tfr_pkg::SYNC_00) begin
              position_nxt = pos_bump;
              if (pos_bump == tfr_pkg::POS_55) begin
                phase_nxt = tfr_pkg::PH_55;
              end
            end else begin
              sync_err = 1'b1;
            end
          end
          tfr_pkg::PH_55: begin
            if (in_item.data_byte == tfr_pkg::SYNC_55) begin
              position_nxt = pos_bump;
              if (pos_bump == tfr_pkg::POS_HEAD) begin
                phase_nxt = tfr_pkg::PH_HEAD;
              end
            end else begin
              sync_err = 1'b1;
            end
          end
          tfr_pkg::PH_HEAD: begin
            if (position_r == tfr_pkg::POS_LEN_L) begin
              length_low_nxt = in_item.data_byte;
            end
            if (position_r == tfr_pkg::POS_LEN_H) begin
              length_high_nxt = in_item.data_byte;
            end
            position_nxt = pos_bump;
            if (pos_bump == tfr_pkg::POS_HEND) begin
              blen              = {length_high_nxt, length_low_nxt} + 16'd2;
              position_nxt      = tfr_pkg::POS_BODY;
              body_end_nxt      = tfr_pkg::POS_BODY + {1'b0, blen};
              phase_nxt         = tfr_pkg::PH_BODY;
              res.event_res     = tfr_pkg::EV_HEADER;
              res.record_length = tfr_pkg::HEAD_LEN;
            end
          end
          tfr_pkg::PH_BODY: begin
            position_nxt = pos_bump;
            if (pos_bump == body_end_r) begin
              res.event_res     = tfr_pkg::EV_RECORD;
              res.record_length = {1'b0, 16'(body_end_r - tfr_pkg::POS_BODY)};
              phase_nxt         = tfr_pkg::PH_WAIT;
              position_nxt      = tfr_pkg::POS_START;
              gap_ticks_nxt     = tfr_pkg::WAIT_LOAD;
            end
          end
          tfr_pkg::PH_WAIT, tfr_pkg::PH_EXT: begin
            phase_nxt     = tfr_pkg::PH_EXT;
            position_nxt  = pos_bump;
            gap_ticks_nxt = tfr_pkg::GAP_LOAD;
          end
          default: begin
            sync_err = 1'b1;
          end
        endcase
        if (sync_err) begin
          res.event_res = tfr_pkg::EV_SYNC;
          phase_nxt     = tfr_pkg::PH_FF;
          position_nxt  = tfr_pkg::POS_START;
        end
      end
    end else begin
      if (phase_r == tfr_pkg::PH_WAIT) begin
        gap_ticks_nxt = gap_dec;
        if (gap_dec == 16'd0) begin
          if (position_r > tfr_pkg::POS_START) begin
            res.event_res     = tfr_pkg::EV_EXT;
            res.record_length = position_r - tfr_pkg::POS_START;
          end
          phase_nxt    = tfr_pkg::PH_FF;
          position_nxt = tfr_pkg::POS_START;
        end
      end else if (phase_r == tfr_pkg::PH_EXT) begin
        gap_ticks_nxt = gap_dec;
        if (gap_dec == 16'd0) begin
          res.event_res     = tfr_pkg::EV_EXT;
          res.record_length = position_r - tfr_pkg::POS_START;
          if (in_item.host_accepts) begin
            phase_nxt     = tfr_pkg::PH_WAIT;
            position_nxt  = tfr_pkg::POS_START;
            gap_ticks_nxt = tfr_pkg::REWAIT_LOAD;
          end else begin
            phase_nxt    = tfr_pkg::PH_FF;
            position_nxt = tfr_pkg::POS_START;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= tfr_pkg::PH_FF;
      position_r    <= tfr_pkg::POS_START;
      body_end_r    <= '0;
      length_low_r  <= '0;
      length_high_r <= '0;
      gap_ticks_r   <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      position_r    <= position_nxt;
      body_end_r    <= body_end_nxt;
      length_low_r  <= length_low_nxt;
      length_high_r <= length_high_nxt;
      gap_ticks_r   <= gap_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (accept) begin
        out_item_r <= res;
      end
    end else if (accept) begin
      skid_item_r <= res;
    end
  end

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid register holds an item while the output register is empty.");

  a_position_floor: assert property (@(posedge clk) disable iff (!rst_n)
    position_r >= tfr_pkg::POS_START)
    else $error("Byte position fell below the start of the buffer.");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tfr_pkg::PH_HEAD) |->
      (position_r >= tfr_pkg::POS_HEAD && position_r < tfr_pkg::POS_HEND))
    else $error("Header phase with a position outside the header.");

  a_busy_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.command == tfr_pkg::CMD_BYTE && in_item.receiver_busy) |=>
      (phase_r == tfr_pkg::PH_FF && position_r == tfr_pkg::POS_START))
    else $error("A byte during playback did not restart framing.");
`endif

endmodule

FILE: test/tb_tape_record_frame_recognizer_unit.sv
// Self-checking testbench for the tape record frame recognizer, with its own framing predictor.
module tb_tape_record_frame_recognizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    tfr_pkg::in_item_t  it;
    logic               typed;
    tfr_pkg::out_item_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tfr_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tfr_pkg::out_item_t out_item;

  tfr_pkg::phase_t ph;
  logic [16:0]     pos;
  logic [16:0]     body_end_pos;
  logic [7:0]      len_lo;
  logic [7:0]      len_hi;
  logic [15:0]     gap_left;

  tfr_pkg::out_item_t pending_reports[$];
  stim_row_t          opening[$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 in_idle_odds = 0;
  int                 rx_stall_odds = 0;
  int                 stall_left = 0;
  bit                 calm = 1'b0;

  tape_record_frame_recognizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void restart_framing();
    ph = tfr_pkg::PH_FF;
    pos = tfr_pkg::POS_START;
  endfunction

  function automatic void advance_pos();
    if (pos != tfr_pkg::POS_MAX) begin
      pos = pos + 17'd1;
    end
  endfunction

  function automatic tfr_pkg::out_item_t frame_recognize(input tfr_pkg::in_item_t it);
    tfr_pkg::out_item_t r;
    logic [15:0]        blen;
    r = '0;
    if (it.command == tfr_pkg::CMD_BYTE) begin
      if (it.receiver_busy) begin
        restart_framing();
        r.event_res = tfr_pkg::EV_BUSY;
      end else begin
        r.byte_index = pos;
        r.stored_byte = it.data_byte;
        r.event_res = tfr_pkg::EV_STORED;
        case (ph)
          tfr_pkg::PH_FF: begin
            if (it.data_byte == tfr_pkg::SYNC_FF) begin
              advance_pos();
              if (pos == tfr_pkg::POS_00) ph = tfr_pkg::PH_00;
            end else begin
              r.event_res = tfr_pkg::EV_SYNC;
            end
          end
          tfr_pkg::PH_00: begin
            if (it.data_byte == tfr_pkg::SYNC_00) begin
              advance_pos();
              if (pos == tfr_pkg::POS_55) ph = tfr_pkg::PH_55;
            end else begin
              r.event_res = tfr_pkg::EV_SYNC;
            end
          end
          tfr_pkg::PH_55: begin
            if (it.data_byte == tfr_pkg::SYNC_55) begin
              advance_pos();
              if (pos == tfr_pkg::POS_HEAD) ph = tfr_pkg::PH_HEAD;
            end else begin
              r.event_res = tfr_pkg::EV_SYNC;
            end
          end
          tfr_pkg::PH_HEAD: begin
            if (pos == tfr_pkg::POS_LEN_L) len_lo = it.data_byte;
            if (pos == tfr_pkg::POS_LEN_H) len_hi = it.data_byte;
            advance_pos();
            if (pos == tfr_pkg::POS_HEND) begin
              blen = {len_hi, len_lo} + 16'd2;
              pos = tfr_pkg::POS_BODY;
              body_end_pos = tfr_pkg::POS_BODY + {1'b0, blen};
              ph = tfr_pkg::PH_BODY;
              r.event_res = tfr_pkg::EV_HEADER;
              r.record_length = tfr_pkg::HEAD_LEN;
            end
          end
          tfr_pkg::PH_BODY: begin
            advance_pos();
            if (pos == body_end_pos) begin
              blen = 16'(body_end_pos - tfr_pkg::POS_BODY);
              r.event_res = tfr_pkg::EV_RECORD;
              r.record_length = {1'b0, blen};
              ph = tfr_pkg::PH_WAIT;
              pos = tfr_pkg::POS_START;
              gap_left = tfr_pkg::WAIT_LOAD;
            end
          end
          tfr_pkg::PH_WAIT, tfr_pkg::PH_EXT: begin
            ph = tfr_pkg::PH_EXT;
            advance_pos();
            gap_left = tfr_pkg::GAP_LOAD;
          end
          default: begin
            r.event_res = tfr_pkg::EV_SYNC;
          end
        endcase
        if (r.event_res == tfr_pkg::EV_SYNC) restart_framing();
      end
    end else if (ph == tfr_pkg::PH_WAIT) begin
      gap_left = gap_left - 16'd1;
      if (gap_left == 16'd0) begin
        if (pos > tfr_pkg::POS_START) begin
          r.event_res = tfr_pkg::EV_EXT;
          r.record_length = pos - tfr_pkg::POS_START;
        end
        restart_framing();
      end
    end else if (ph == tfr_pkg::PH_EXT) begin
      gap_left = gap_left - 16'd1;
      if (gap_left == 16'd0) begin
        r.event_res = tfr_pkg::EV_EXT;
        r.record_length = pos - tfr_pkg::POS_START;
        if (it.host_accepts) begin
          ph = tfr_pkg::PH_WAIT;
          pos = tfr_pkg::POS_START;
          gap_left = tfr_pkg::REWAIT_LOAD;
        end else begin
          restart_framing();
        end
      end
    end
    return r;
  endfunction

  function automatic tfr_pkg::in_item_t mk_byte(input logic [7:0] b, input logic busy);
    tfr_pkg::in_item_t it;
    it.command = tfr_pkg::CMD_BYTE;
    it.data_byte = b;
    it.receiver_busy = busy;
    it.host_accepts = 1'($urandom);
    return it;
  endfunction

  function automatic tfr_pkg::in_item_t mk_tick(input logic acc);
    tfr_pkg::in_item_t it;
    it.command = tfr_pkg::CMD_TICK;
    it.data_byte = 8'($urandom);
    it.receiver_busy = 1'($urandom);
    it.host_accepts = acc;
    return it;
  endfunction

  function automatic tfr_pkg::in_item_t noise_item();
    if ($urandom_range(0, 1) == 0) begin
      return mk_tick(1'($urandom));
    end
    return mk_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endfunction

  function automatic tfr_pkg::out_item_t mk_report(input logic [2:0] ev,
                                                   input logic [16:0] idx,
                                                   input logic [7:0] sb,
                                                   input logic [16:0] len);
    tfr_pkg::out_item_t r;
    r.event_res = ev;
    r.byte_index = idx;
    r.stored_byte = sb;
    r.record_length = len;
    return r;
  endfunction

  task automatic add_row(input tfr_pkg::in_item_t it, input logic typed,
                         input tfr_pkg::out_item_t want);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    opening.push_back(row);
  endtask

  task automatic send_item(input tfr_pkg::in_item_t it, input logic typed,
                           input tfr_pkg::out_item_t want);
    tfr_pkg::out_item_t predicted;
    if (in_idle_odds != 0 && $urandom_range(1, in_idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = frame_recognize(it);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  task automatic push(input tfr_pkg::in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Extended bytes after a saved record; with full_gap set, the block is closed by a full gap of ticks.
  task automatic run_extended(input bit full_gap);
    int   nbytes;
    logic acc;
    nbytes = full_gap ? $urandom_range(1, 12) : $urandom_range(0, 24);
    repeat (nbytes) begin
      push(mk_byte(8'($urandom), 1'b0));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 8)) push(mk_tick(1'($urandom)));
      end
    end
    if (full_gap) begin
      repeat (gap_left - 16'd1) push(mk_tick(1'($urandom)));
      acc = 1'($urandom_range(0, 1));
      push(mk_tick(acc));
    end
    if ($urandom_range(0, 1) == 0) begin
      push(mk_byte(8'($urandom), 1'b1));
    end
  endtask

  // Preamble, header and body of one record, then its extended bytes; a broken record ends at a bad or busy byte.
  task automatic run_record(input logic [15:0] len_word, input bit broken, input bit full_gap);
    int          brk;
    logic [7:0]  b;
    logic [15:0] body_len;
    brk = broken ? $urandom_range(0, 62) : -1;
    for (int i = 0; i < 63; i++) begin
      if ($urandom_range(0, 15) == 0) push(mk_tick(1'($urandom)));
      if (i < 16) b = tfr_pkg::SYNC_FF;
      else if (i < 32) b = tfr_pkg::SYNC_00;
      else if (i < 48) b = tfr_pkg::SYNC_55;
      else if (i == 52) b = len_word[7:0];
      else if (i == 53) b = len_word[15:8];
      else b = 8'($urandom);
      if (i == brk) begin
        if (i >= 48 || $urandom_range(0, 1) == 0) begin
          push(mk_byte(8'($urandom), 1'b1));
        end else begin
          push(mk_byte(b ^ 8'($urandom_range(1, 255)), 1'b0));
        end
        return;
      end
      push(mk_byte(b, 1'b0));
    end
    body_len = len_word + 16'd2;
    if (body_len == 16'd0) begin
      // The body end is never met, so only a busy byte leaves the body.
      repeat ($urandom_range(8, 40)) push(mk_byte(8'($urandom), 1'b0));
      push(mk_byte(8'($urandom), 1'b1));
      return;
    end
    repeat (body_len) push(mk_byte(8'($urandom), 1'b0));
    run_extended(full_gap);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
      stall_left <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    tfr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected item ev=%0d idx=%0d byte=%02h len=%0d", $realtime,
                   out_item.event_res, out_item.byte_index, out_item.stored_byte,
                   out_item.record_length);
        end
      end else begin
        want = pending_reports.pop_front();
        if (out_item.event_res != want.event_res || out_item.byte_index != want.byte_index ||
            out_item.stored_byte != want.stored_byte ||
            out_item.record_length != want.record_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch expected ev=%0d idx=%0d byte=%02h len=%0d", $realtime,
                     want.event_res, want.byte_index, want.stored_byte,
                     want.record_length);
            $display("%0t:          got ev=%0d idx=%0d byte=%02h len=%0d", $realtime,
                     out_item.event_res, out_item.byte_index, out_item.stored_byte,
                     out_item.record_length);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_tape_record_frame_recognizer_unit NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [15:0] len_word;
    restart_framing();
    body_end_pos = '0;
    len_lo = '0;
    len_hi = '0;
    gap_left = '0;

    add_row(mk_tick(1'b1), 1'b1, mk_report(tfr_pkg::EV_NONE, 17'd0, 8'h00, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_STORED, tfr_pkg::POS_START, tfr_pkg::SYNC_FF, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b1), 1'b1,
            mk_report(tfr_pkg::EV_BUSY, 17'd0, 8'h00, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_00, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_SYNC, tfr_pkg::POS_START, tfr_pkg::SYNC_00, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_55, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_SYNC, tfr_pkg::POS_START, tfr_pkg::SYNC_55, 17'd0));
    add_row(mk_byte(8'hFE, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_SYNC, tfr_pkg::POS_START, 8'hFE, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_STORED, 17'd2, tfr_pkg::SYNC_FF, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_STORED, 17'd3, tfr_pkg::SYNC_FF, 17'd0));
    add_row(mk_tick(1'b0), 1'b1, mk_report(tfr_pkg::EV_NONE, 17'd0, 8'h00, 17'd0));
    add_row(mk_byte(8'h7F, 1'b0), 1'b1, mk_report(tfr_pkg::EV_SYNC, 17'd4, 8'h7F, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_00, 1'b1), 1'b1,
            mk_report(tfr_pkg::EV_BUSY, 17'd0, 8'h00, 17'd0));
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b0), 1'b1,
            mk_report(tfr_pkg::EV_STORED, 17'd2, tfr_pkg::SYNC_FF, 17'd0));
    add_row(mk_byte(8'h80, 1'b0), 1'b1, mk_report(tfr_pkg::EV_SYNC, 17'd3, 8'h80, 17'd0));
    add_row(mk_tick(1'b0), 1'b1, mk_report(tfr_pkg::EV_NONE, 17'd0, 8'h00, 17'd0));
    add_row(mk_byte(8'h01, 1'b0), 1'b0, '0);
    add_row(mk_byte(8'hAA, 1'b0), 1'b0, '0);
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b0), 1'b0, '0);
    add_row(mk_byte(tfr_pkg::SYNC_FF, 1'b1), 1'b0, '0);
    add_row(mk_tick(1'b1), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_odds = 6;
    rx_stall_odds = 6;
    foreach (opening[i]) begin
      send_item(opening[i].it, opening[i].typed, opening[i].want);
    end

    for (int s = 0; s < 4; s++) begin
      case ($urandom_range(0, 2))
        0: in_idle_odds = 0;
        1: in_idle_odds = 3;
        default: in_idle_odds = 16;
      endcase
      case ($urandom_range(0, 2))
        0: rx_stall_odds = 0;
        1: rx_stall_odds = 3;
        default: rx_stall_odds = 16;
      endcase
      if (s == 3) begin
        calm = 1'b1;
        in_idle_odds = 0;
      end
      case ($urandom_range(0, 9))
        0: len_word = 16'hFFFF;
        1: len_word = 16'h0000;
        default: len_word = 16'($urandom_range(0, 24));
      endcase
      if (s == 1) begin
        len_word = 16'hFFFE;
      end
      run_record(len_word, s != 1 && s != 2 && $urandom_range(0, 2) == 0, s == 2);
      repeat ($urandom_range(0, 24)) push(noise_item());
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_tape_record_frame_recognizer_unit OK");
    end else begin
      $display("tb_tape_record_frame_recognizer_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: tape_record_frame_recognizer_unit.f
src/tfr_pkg.sv
src/tape_record_frame_recognizer_unit.sv
test/tb_tape_record_frame_recognizer_unit.sv
